/* rtl/core/fcp_pkg.sv */
// Shared types and constants of the framed command parser with reply unit.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.

package fcp_pkg;

   // Frame header bytes, used for incoming frames and for outgoing replies.
   localparam logic [7:0] HDR0 = 8'hFF;
   localparam logic [7:0] HDR1 = 8'hAA;

   // Fixed bytes of a reply frame.
   localparam logic [7:0] REPLY_SIZE   = 8'h05;
   localparam logic [7:0] REPLY_CMD    = 8'h00;
   localparam logic [7:0] REPLY_FOOTER = 8'h00;

   // Command codes.
   localparam logic [7:0] CMD_BAUD      = 8'h00;
   localparam logic [7:0] CMD_HARMED_A  = 8'h07;
   localparam logic [7:0] CMD_STABLE_A  = 8'h08;
   localparam logic [7:0] CMD_UNHARM_A  = 8'h09;
   localparam logic [7:0] CMD_HARMED_B  = 8'h0A;
   localparam logic [7:0] CMD_STABLE_B  = 8'h0B;
   localparam logic [7:0] CMD_UNHARM_B  = 8'h0C;
   localparam logic [7:0] CMD_DETECT    = 8'h0D;
   localparam logic [7:0] CMD_VERSION   = 8'h13;

   // Victim codes.
   localparam logic [1:0] VICTIM_NONE     = 2'd0;
   localparam logic [1:0] VICTIM_HARMED   = 2'd1;
   localparam logic [1:0] VICTIM_STABLE   = 2'd2;
   localparam logic [1:0] VICTIM_UNHARMED = 2'd3;

   // Fixed reply words.
   localparam logic [31:0] VERSION_WORD = 32'd1;
   localparam logic [31:0] BAUD_WORD    = 32'd115200;

   // Reply frame length and byte positions.
   localparam int unsigned REPLY_LEN = 9;
   localparam int unsigned IDX_W     = 4;
   localparam logic [IDX_W-1:0] IDX_HDR0   = 4'd0;
   localparam logic [IDX_W-1:0] IDX_HDR1   = 4'd1;
   localparam logic [IDX_W-1:0] IDX_SIZE   = 4'd2;
   localparam logic [IDX_W-1:0] IDX_CMD    = 4'd3;
   localparam logic [IDX_W-1:0] IDX_P0     = 4'd4;
   localparam logic [IDX_W-1:0] IDX_P1     = 4'd5;
   localparam logic [IDX_W-1:0] IDX_P2     = 4'd6;
   localparam logic [IDX_W-1:0] IDX_P3     = 4'd7;
   localparam logic [IDX_W-1:0] IDX_FOOTER = 4'd8;

   // One pending reply: its payload word and the victim code it reports.
   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  victim;
   } fcp_entry_type;

   // Hand-over from the parser to the reply queue.
   typedef struct packed {
      logic          push;
      fcp_entry_type entry;
   } fcp_push_type;

endpackage

/* rtl/core/fcp_front.sv */
// Frame parser: accepts received bytes, checks header, size and check byte,
// and hands replies to the queue. Depends on fcp_pkg.

module fcp_front #(
   parameter int MAX_FRAME = 18
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept_i,
   input  logic [7:0]           rx_byte_i,
   input  logic                 csr_wr_en_i,
   input  logic [31:0]          csr_wr_data_i,
   output fcp_pkg::fcp_push_type push_o
);

   localparam int CW = $clog2(MAX_FRAME + 1);
   localparam logic [8:0] MAX_FRAME_W = 9'(MAX_FRAME);

   logic [CW-1:0] byte_count_ff, byte_count_in, cnt_inc;
   logic [7:0]    frame_size_ff, frame_size_in;
   logic [7:0]    command_code_ff, command_code_in;
   logic [1:0]    victim_ff, victim_in;
   logic [31:0]   detect_reply_ff;
   logic [7:0]    cmd_eff;
   logic [8:0]    total;
   logic          is_hit;
   logic [31:0]   hit_word;
   logic [1:0]    hit_victim;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff   <= '0;
         frame_size_ff   <= '0;
         command_code_ff <= '0;
         victim_ff       <= fcp_pkg::VICTIM_NONE;
         detect_reply_ff <= '0;
      end else begin
         if (accept_i) begin
            byte_count_ff   <= byte_count_in;
            frame_size_ff   <= frame_size_in;
            command_code_ff <= command_code_in;
            victim_ff       <= victim_in;
         end
         if (csr_wr_en_i) begin
            detect_reply_ff <= csr_wr_data_i;
         end
      end
   end

   assign cnt_inc = byte_count_ff + CW'(1);
   assign cmd_eff = (cnt_inc == CW'(4)) ? rx_byte_i : command_code_ff;
   assign total   = {1'b0, frame_size_ff} + 9'd4;

   // Command decoder for frames of size one.
   always_comb begin
      is_hit     = 1'b1;
      hit_word   = detect_reply_ff;
      hit_victim = victim_ff;
      unique case (cmd_eff) inside
         fcp_pkg::CMD_VERSION: begin
            hit_word = fcp_pkg::VERSION_WORD;
         end
         fcp_pkg::CMD_BAUD: begin
            hit_word = fcp_pkg::BAUD_WORD;
         end
         fcp_pkg::CMD_HARMED_A, fcp_pkg::CMD_HARMED_B: begin
            hit_victim = fcp_pkg::VICTIM_HARMED;
         end
         fcp_pkg::CMD_STABLE_A, fcp_pkg::CMD_STABLE_B: begin
            hit_victim = fcp_pkg::VICTIM_STABLE;
         end
         fcp_pkg::CMD_UNHARM_A, fcp_pkg::CMD_UNHARM_B: begin
            hit_victim = fcp_pkg::VICTIM_UNHARMED;
         end
         fcp_pkg::CMD_DETECT: begin
            hit_word = detect_reply_ff;
         end
         default: begin
            is_hit = 1'b0;
         end
      endcase
   end

   always_comb begin
      byte_count_in   = cnt_inc;
      frame_size_in   = frame_size_ff;
      command_code_in = command_code_ff;
      victim_in       = victim_ff;
      push_o          = '0;
      if (cnt_inc == CW'(1)) begin
         if (rx_byte_i != fcp_pkg::HDR0) begin
            byte_count_in   = '0;
            frame_size_in   = '0;
            command_code_in = '0;
         end
      end else if (cnt_inc == CW'(2)) begin
         if (rx_byte_i != fcp_pkg::HDR1) begin
            byte_count_in   = '0;
            frame_size_in   = '0;
            command_code_in = '0;
         end
      end else if (cnt_inc == CW'(3)) begin
         frame_size_in = rx_byte_i;
      end else begin
         command_code_in = cmd_eff;
         if ((cnt_inc == CW'(4)) && (total > MAX_FRAME_W)) begin
            byte_count_in   = '0;
            frame_size_in   = '0;
            command_code_in = '0;
         end else if (9'(cnt_inc) < total) begin
            // Still inside the frame body.
         end else if ({1'b0, rx_byte_i} != ({1'b0, cmd_eff} + 9'd1)) begin
            byte_count_in   = '0;
            frame_size_in   = '0;
            command_code_in = '0;
         end else begin
            byte_count_in = '0;
            frame_size_in = '0;
            if ((frame_size_ff == 8'd1) && is_hit) begin
               victim_in           = hit_victim;
               push_o.push         = accept_i;
               push_o.entry.word   = hit_word;
               push_o.entry.victim = hit_victim;
            end
         end
      end
   end

endmodule

/* rtl/core/fcp_queue.sv */
// Two-entry reply queue between the parser and the reply serialiser.
// Depends on fcp_pkg.

module fcp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  fcp_pkg::fcp_push_type  push_i,
   input  logic                   pop_i,
   output logic                   full_o,
   output logic                   valid_o,
   output fcp_pkg::fcp_entry_type head_o
);

   fcp_pkg::fcp_entry_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push_i.push) begin
         slot_ff[wr_ptr_ff] <= push_i.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push_i.push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop_i) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push_i.push, pop_i})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   assign full_o  = (count_ff == 2'd2);
   assign valid_o = (count_ff != 2'd0);
   assign head_o  = slot_ff[rd_ptr_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push_i.push && full_o && !pop_i))
      else $error("reply queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop_i && !valid_o))
      else $error("reply queue read while empty");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("reply queue count out of range");

endmodule

/* rtl/core/fcp_back.sv */
// Reply serialiser: turns one queued reply into the nine bytes of a reply
// frame on the result channel. Depends on fcp_pkg.

module fcp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid_i,
   input  fcp_pkg::fcp_entry_type q_head_i,
   output logic                   pop_o,
   output logic                   rsp_valid_o,
   input  logic                   rsp_stall_i,
   output logic [7:0]             tx_byte_o,
   output logic                   tx_last_o,
   output logic [1:0]             victim_code_o
);

   logic                        busy_ff;
   logic [fcp_pkg::IDX_W-1:0]   idx_ff;
   fcp_pkg::fcp_entry_type      entry_ff;
   logic                        take, last, load;

   assign last  = (idx_ff == fcp_pkg::IDX_FOOTER);
   assign take  = busy_ff && !rsp_stall_i;
   assign load  = q_valid_i && (!busy_ff || (take && last));
   assign pop_o = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         idx_ff  <= fcp_pkg::IDX_HDR0;
      end else if (take) begin
         if (last) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= q_head_i;
      end
   end

   always_comb begin
      unique case (idx_ff)
         fcp_pkg::IDX_HDR0:   tx_byte_o = fcp_pkg::HDR0;
         fcp_pkg::IDX_HDR1:   tx_byte_o = fcp_pkg::HDR1;
         fcp_pkg::IDX_SIZE:   tx_byte_o = fcp_pkg::REPLY_SIZE;
         fcp_pkg::IDX_CMD:    tx_byte_o = fcp_pkg::REPLY_CMD;
         fcp_pkg::IDX_P0:     tx_byte_o = entry_ff.word[7:0];
         fcp_pkg::IDX_P1:     tx_byte_o = entry_ff.word[15:8];
         fcp_pkg::IDX_P2:     tx_byte_o = entry_ff.word[23:16];
         fcp_pkg::IDX_P3:     tx_byte_o = entry_ff.word[31:24];
         default:             tx_byte_o = fcp_pkg::REPLY_FOOTER;
      endcase
   end

   assign rsp_valid_o   = busy_ff;
   assign tx_last_o     = last;
   assign victim_code_o = entry_ff.victim;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= fcp_pkg::IDX_FOOTER))
      else $error("reply byte index beyond footer");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (take && last && !q_valid_i) |=> !busy_ff)
      else $error("serialiser still busy after final byte with nothing queued");

   a_step: assert property (@(posedge clock) disable iff (reset)
      (take && !last) |=> (busy_ff && (idx_ff == $past(idx_ff) + 4'd1)))
      else $error("reply byte index did not advance");

endmodule

/* rtl/core/framed_command_parser_with_reply_unit.sv */
// Top level of the framed command parser with reply unit.
// Depends on fcp_pkg, fcp_front, fcp_queue and fcp_back.
//
// The request channel (req_valid, req_stall, req_rx_byte) carries one byte from
// the serial link per request; the result channel (rsp_valid, rsp_stall,
// rsp_tx_byte, rsp_tx_last, rsp_victim_code) carries reply frames of nine bytes,
// with rsp_tx_last high on the footer byte. csr_wr_en and csr_wr_data write the
// word sent in replies to victim commands; the user must write it only while no
// reply is pending, since the block itself does not enforce this. The parser
// takes one request per cycle while req_stall is low. The request that closes
// a good frame puts its reply into a two-entry queue; with the serialiser idle,
// the reply is registered in the queue, then loaded into the serialiser, and
// its bytes go out one byte per cycle on the result channel when not stalled.
// req_stall rises only when the queue is full, which takes two queued replies
// behind the one being sent.
// A synchronous, active-high reset clears the parser, the victim code, the
// detect word, the queue and the serialiser. When the receiver stalls, the
// current byte holds and the parser keeps running until the queue fills.

module framed_command_parser_with_reply_unit #(
   parameter int MAX_FRAME = 18
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_tx_last,
   output logic [1:0]  rsp_victim_code,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   fcp_pkg::fcp_push_type  push;
   fcp_pkg::fcp_entry_type head;
   logic                   q_full, q_valid, pop, req_accept;

   // The queue can always take a reply when it is not full, so that is the
   // only reason to hold off a request.
   assign req_stall  = q_full;
   assign req_accept = req_valid && !q_full;

   fcp_front #(
      .MAX_FRAME (MAX_FRAME)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept_i      (req_accept),
      .rx_byte_i     (req_rx_byte),
      .csr_wr_en_i   (csr_wr_en),
      .csr_wr_data_i (csr_wr_data),
      .push_o        (push)
   );

   fcp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .pop_i   (pop),
      .full_o  (q_full),
      .valid_o (q_valid),
      .head_o  (head)
   );

   fcp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid_i     (q_valid),
      .q_head_i      (head),
      .pop_o         (pop),
      .rsp_valid_o   (rsp_valid),
      .rsp_stall_i   (rsp_stall),
      .tx_byte_o     (rsp_tx_byte),
      .tx_last_o     (rsp_tx_last),
      .victim_code_o (rsp_victim_code)
   );

endmodule

/* verif/fcp_reply_checker.sv */
// Checker for the framed command parser: watches both channels and the register port,
// predicts every reply byte and compares each accepted one with its expectation.
// Depends on fcp_pkg.

module fcp_reply_checker #(
   parameter int MAX_FRAME = 18
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_tx_byte,
   input  logic        rsp_tx_last,
   input  logic [1:0]  rsp_victim_code,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output int unsigned errors,
   output int unsigned pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_last;
      logic [1:0] victim;
   } reply_byte_type;

   reply_byte_type reply_bytes_due[$];
   reply_byte_type due;
   reply_byte_type seen;

   // Shadow of the parser state and of the detect word.
   logic [4:0]  rx_count;
   logic [7:0]  rx_size;
   logic [7:0]  rx_cmd;
   logic [1:0]  victim_now;
   logic [31:0] detect_word;

   task automatic resync();
      rx_count = '0;
      rx_size  = '0;
      rx_cmd   = '0;
   endtask

   task automatic queue_reply(input logic [31:0] word);
      logic [7:0] frame [fcp_pkg::REPLY_LEN];
      int k;
      frame = '{fcp_pkg::HDR0, fcp_pkg::HDR1, fcp_pkg::REPLY_SIZE, fcp_pkg::REPLY_CMD,
                word[7:0], word[15:8], word[23:16], word[31:24], fcp_pkg::REPLY_FOOTER};
      for (k = 0; k < fcp_pkg::REPLY_LEN; k++) begin
         reply_bytes_due.push_back('{frame[k], k == fcp_pkg::REPLY_LEN - 1, victim_now});
      end
   endtask

   // A frame whose check byte matched: only size-one frames with a known command answer.
   task automatic close_good_frame();
      logic [31:0] word;
      logic answer;
      answer = 1'b1;
      word = detect_word;
      if (rx_size != 8'd1) begin
         answer = 1'b0;
      end else begin
         case (rx_cmd)
            fcp_pkg::CMD_VERSION: word = fcp_pkg::VERSION_WORD;
            fcp_pkg::CMD_BAUD: word = fcp_pkg::BAUD_WORD;
            fcp_pkg::CMD_HARMED_A, fcp_pkg::CMD_HARMED_B:
               victim_now = fcp_pkg::VICTIM_HARMED;
            fcp_pkg::CMD_STABLE_A, fcp_pkg::CMD_STABLE_B:
               victim_now = fcp_pkg::VICTIM_STABLE;
            fcp_pkg::CMD_UNHARM_A, fcp_pkg::CMD_UNHARM_B:
               victim_now = fcp_pkg::VICTIM_UNHARMED;
            fcp_pkg::CMD_DETECT: ;
            default: answer = 1'b0;
         endcase
      end
      if (answer) begin
         queue_reply(word);
      end
      rx_count = '0;
      rx_size  = '0;
   endtask

   task automatic take_rx_byte(input logic [7:0] b);
      rx_count = rx_count + 5'd1;
      if (rx_count == 5'd1) begin
         if (b != fcp_pkg::HDR0) resync();
      end else if (rx_count == 5'd2) begin
         if (b != fcp_pkg::HDR1) resync();
      end else if (rx_count == 5'd3) begin
         rx_size = b;
      end else begin
         if (rx_count == 5'd4) rx_cmd = b;
         if (rx_count == 5'd4 && int'(rx_size) + 4 > MAX_FRAME) begin
            resync();
         end else if (int'(rx_count) >= int'(rx_size) + 4) begin
            if ({1'b0, b} != {1'b0, rx_cmd} + 9'd1) resync();
            else close_good_frame();
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reply_bytes_due.delete();
         resync();
         victim_now  = fcp_pkg::VICTIM_NONE;
         detect_word = '0;
         errors      = 0;
      end else begin
         if (csr_wr_en) detect_word = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_tx_byte, rsp_tx_last, rsp_victim_code};
            if (reply_bytes_due.size() == 0) begin
               if (errors < 10) begin
                  $display("checker: reply byte %02h last %0b victim %0d with nothing expected",
                           seen.tx_byte, seen.tx_last, seen.victim);
               end
               errors++;
            end else begin
               due = reply_bytes_due.pop_front();
               if (seen.tx_byte !== due.tx_byte || seen.tx_last !== due.tx_last ||
                   seen.victim !== due.victim) begin
                  if (errors < 10) begin
                     $display("checker: expected byte %02h last %0b victim %0d, got %02h %0b %0d",
                              due.tx_byte, due.tx_last, due.victim,
                              seen.tx_byte, seen.tx_last, seen.victim);
                  end
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) take_rx_byte(req_rx_byte);
      end
      pending = reply_bytes_due.size();
   end

endmodule

/* verif/testbench.sv */
// Top of the testbench for the framed command parser with reply unit.
// Depends on fcp_pkg, the unit itself and fcp_reply_checker.

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_FRAME = 18;
   // Far above the slowest correct run: every request waiting out a full idle burst
   // and every reply byte a full stall burst.
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned ITEM_TARGET = 450;
   localparam int unsigned PHASES = 5;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_tx_last;
   logic [1:0]  rsp_victim_code;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = 32'h0;

   int unsigned errors;
   int unsigned pending;
   int unsigned cycle_count = 0;
   int unsigned requests_sent = 0;
   bit          quiet = 1'b0;

   // Every command the unit answers, so that random frames can pick one at will.
   logic [7:0] known_cmds [9] = '{fcp_pkg::CMD_BAUD, fcp_pkg::CMD_HARMED_A,
                                  fcp_pkg::CMD_STABLE_A, fcp_pkg::CMD_UNHARM_A,
                                  fcp_pkg::CMD_HARMED_B, fcp_pkg::CMD_STABLE_B,
                                  fcp_pkg::CMD_UNHARM_B, fcp_pkg::CMD_DETECT,
                                  fcp_pkg::CMD_VERSION};

   always #5ns clock = ~clock;

   framed_command_parser_with_reply_unit #(.MAX_FRAME(MAX_FRAME)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_tx_last(rsp_tx_last),
      .rsp_victim_code(rsp_victim_code),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   fcp_reply_checker #(.MAX_FRAME(MAX_FRAME)) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_tx_last(rsp_tx_last),
      .rsp_victim_code(rsp_victim_code),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .errors(errors),
      .pending(pending)
   );

   // The receiver stalls in bursts of random length separated by calm stretches of
   // random length, so that stalls land on every byte of a reply. Once the run has
   // gone quiet it never stalls again.
   int unsigned stall_left = 0;
   int unsigned calm_left = 0;

   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (calm_left > 0) begin
         rsp_stall <= 1'b0;
         calm_left--;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 13);
         else calm_left = $urandom_range(1, 40);
      end
   end

   // Watchdog: a run that has not finished by the cycle limit has hung somewhere.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // Presents one received byte and waits until the unit has taken the request.
   // Before it, the sender may fall idle for a burst of random length. Inputs only
   // ever change at the falling edge, and req_stall is looked at on the rising edge.
   task automatic send_request(input logic [7:0] b);
      int unsigned gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 13);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   // Header, size and command, then the body and the check byte where the size
   // leaves room for them. An oversized frame is dropped by the unit on its command
   // byte, and a zero size makes the command byte the check byte, so both stop there.
   task automatic send_frame(input logic [7:0] size, input logic [7:0] cmd,
                             input logic [7:0] check);
      send_request(fcp_pkg::HDR0);
      send_request(fcp_pkg::HDR1);
      send_request(size);
      send_request(cmd);
      if (size != 8'd0 && int'(size) + 4 <= MAX_FRAME) begin
         repeat (int'(size) - 1) send_request(8'($urandom_range(0, 255)));
         send_request(check);
      end
   endtask

   // Drops the request valid, waits until every predicted reply byte has been seen,
   // then waits on in case a frame that needs no reply is still being worked through.
   task automatic wait_until_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_detect_word(input logic [31:0] word);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= word;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 32'($urandom);
   endtask

   // One random piece of traffic. Most of it is well-formed size-one frames carrying a
   // command the unit answers; the rest is good frames that need no answer, frames
   // with a bad check byte, oversized and empty frames, broken headers and plain noise.
   task automatic send_random_traffic();
      int unsigned pick;
      logic [7:0] cmd;
      logic [7:0] size;
      pick = $urandom_range(0, 99);
      cmd = 8'($urandom_range(0, 255));
      if (pick < 55) begin
         cmd = known_cmds[$urandom_range(0, 8)];
         send_frame(8'd1, cmd, cmd + 8'd1);
      end else if (pick < 65) begin
         // Good frame, but either longer than one byte or of size one with a random command.
         if ($urandom_range(0, 1) == 0) size = 8'($urandom_range(2, MAX_FRAME - 4));
         else size = 8'd1;
         send_frame(size, cmd, cmd + 8'd1);
      end else if (pick < 75) begin
         // Bad check byte; a command of FF can never pass, whatever follows it.
         if ($urandom_range(0, 3) == 0) cmd = 8'hFF;
         else if ($urandom_range(0, 1) == 0) cmd = known_cmds[$urandom_range(0, 8)];
         size = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(2, MAX_FRAME - 4)) : 8'd1;
         send_frame(size, cmd, (cmd == 8'hFF) ? 8'h00 : cmd + 8'($urandom_range(2, 255)));
      end else if (pick < 80) begin
         // Oversized: from the smallest size that overruns the store up to 255.
         case ($urandom_range(0, 2))
            0: size = 8'(MAX_FRAME - 3);
            1: size = 8'hFF;
            default: size = 8'($urandom_range(MAX_FRAME - 3, 255));
         endcase
         send_frame(size, cmd, 8'h00);
      end else if (pick < 85) begin
         send_frame(8'd0, cmd, 8'h00);
      end else if (pick < 90) begin
         send_request(fcp_pkg::HDR0);
         send_request(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 6)) send_request(8'($urandom_range(0, 255)));
      end
   endtask

   logic [31:0] phase_words [PHASES];

   initial begin
      phase_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'($urandom), 32'h8000_0001,
                      32'($urandom)};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_detect_word(32'h1234_5678);

      // Directed part: a stray byte before any header, a header broken on its second
      // byte, the version and baud replies, an empty frame, the smallest oversized
      // frame, a command of FF whose check wraps to zero, and a victim command that
      // sends the word just written.
      send_request(8'h00);
      send_request(fcp_pkg::HDR0);
      send_request(8'h55);
      send_frame(8'd1, fcp_pkg::CMD_VERSION, fcp_pkg::CMD_VERSION + 8'd1);
      send_frame(8'd1, fcp_pkg::CMD_BAUD, fcp_pkg::CMD_BAUD + 8'd1);
      send_frame(8'd0, fcp_pkg::CMD_HARMED_A, fcp_pkg::CMD_HARMED_A + 8'd1);
      send_frame(8'(MAX_FRAME - 3), fcp_pkg::CMD_DETECT, 8'h00);
      send_frame(8'd1, 8'hFF, 8'h00);
      send_frame(8'd1, fcp_pkg::CMD_UNHARM_B, fcp_pkg::CMD_UNHARM_B + 8'd1);

      // Random part in phases, each under its own detect word. The register is only
      // written once the unit has gone idle, and the final phase runs without any
      // idling on either side.
      for (int p = 0; p < PHASES; p++) begin
         wait_until_idle();
         write_detect_word(phase_words[p]);
         if (p == PHASES - 1) quiet = 1'b1;
         while (requests_sent < 25 + ITEM_TARGET * (p + 1) / PHASES) send_random_traffic();
      end
      @(negedge clock);
      req_valid <= 1'b0;

      wait_until_idle();
      repeat (20) @(negedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
